// ----- hdl/rf_remote_switch_command_encoder_top_assert.svh -----
// Assertion macros for the radio switch command encoder.
`ifndef RF_REMOTE_SWITCH_COMMAND_ENCODER_TOP_ASSERT_SVH
`define RF_REMOTE_SWITCH_COMMAND_ENCODER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define RFSW_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`define RFSW_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define RFSW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RFSW_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`define RFSW_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define RFSW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- hdl/rfsw_pkg.sv -----
`default_nettype none

package rfsw_pkg;

    localparam int unsigned SYM_W       = 24;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [1:0] CMD_HOUSE     = 2'd0;
    localparam logic [1:0] CMD_HOUSE_VAR = 2'd1;
    localparam logic [1:0] CMD_TEN_POS   = 2'd2;
    localparam logic [1:0] CMD_DIMMER    = 2'd3;

    localparam logic [1:0] KIND_TRI = 2'd0;
    localparam logic [1:0] KIND_POS = 2'd1;
    localparam logic [1:0] KIND_DIM = 2'd2;
    localparam logic [1:0] KIND_BAD = 2'd3;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] house_char;
        logic [7:0] channel;
        logic       turn_on;
        logic [9:0] position_bits;
        logic [7:0] system_code;
        logic [7:0] dim_level;
        logic       smooth_fade;
    } in_word_t;

    typedef struct packed {
        logic [7:0] char0;
        logic [7:0] char1;
        logic [7:0] char2;
        logic [7:0] char3;
        logic [2:0] char_count;
        logic       last_chunk;
        logic       bad_params;
    } out_word_t;

    // Classified command: protocol kind and its symbol bits in send order.
    typedef struct packed {
        logic [1:0]       kind;
        logic [SYM_W-1:0] syms;
    } desc_t;

    typedef struct packed {
        logic full;
        logic valid;
    } q_stat_t;

endpackage

`default_nettype wire

// ----- hdl/rfsw_front.sv -----
`default_nettype none

module rfsw_front
(
    input  wire rfsw_pkg::in_word_t item,
    output rfsw_pkg::desc_t         desc
);

    logic [7:0]  house_off;
    logic [7:0]  chan_off;
    logic [7:0]  sys_off;
    logic        tri_ok;
    logic        dim_ok;
    logic [3:0]  tri_upper;
    logic [11:0] tri_code;
    logic [3:0]  dev_idx;
    logic [9:0]  dev_onehot;
    logic [13:0] dim_code;
    logic [13:0] dim_rev;
    logic [3:0]  lvl;
    logic [5:0]  level_word;
    logic [rfsw_pkg::SYM_W-1:0] dim_syms;

    always_comb
    begin
        house_off = item.house_char - 8'd65;
        chan_off  = item.channel - 8'd1;
        sys_off   = item.system_code - 8'd1;

        tri_ok = (item.house_char >= 8'd65) && (item.house_char <= 8'd80) &&
                 (item.channel >= 8'd1) && (item.channel <= 8'd16);
        dim_ok = (item.channel >= 8'd1) && (item.channel <= 8'd10) &&
                 (item.system_code >= 8'd1) && (item.system_code <= 8'd16) &&
                 (item.dim_level <= 8'd10);

        // Drop the on/off suffix for the variant when switching off.
        if (item.cmd == rfsw_pkg::CMD_HOUSE_VAR && !item.turn_on)
        begin
            tri_upper = 4'd0;
        end
        else
        begin
            tri_upper = {item.turn_on, 3'b110};
        end
        tri_code = {tri_upper, chan_off[3:0], house_off[3:0]};

        dev_idx    = (item.channel == 8'd10) ? 4'd0 : item.channel[3:0];
        dev_onehot = 10'b1 << (4'd9 - dev_idx);
        dim_code   = {sys_off[3:0], dev_onehot};
        for (int i = 0; i < 14; i++)
        begin
            dim_rev[i] = dim_code[13 - i];
        end

        // Swap the ends of the level scale.
        if (item.dim_level == 8'd0)
        begin
            lvl = 4'd10;
        end
        else if (item.dim_level == 8'd10)
        begin
            lvl = 4'd0;
        end
        else
        begin
            lvl = item.dim_level[3:0];
        end
        level_word = {item.smooth_fade, 1'b1, lvl};

        dim_syms = {~^(level_word & 6'h2A), ~^(level_word & 6'h15), level_word,
                    ~^(dim_code & 14'h1555), ~^(dim_code & 14'h2AAA), dim_rev};

        unique case (item.cmd)
            rfsw_pkg::CMD_HOUSE, rfsw_pkg::CMD_HOUSE_VAR:
            begin
                desc.kind = tri_ok ? rfsw_pkg::KIND_TRI : rfsw_pkg::KIND_BAD;
                desc.syms = {12'd0, tri_code};
            end
            rfsw_pkg::CMD_TEN_POS:
            begin
                desc.kind = rfsw_pkg::KIND_POS;
                desc.syms = {12'd0, !item.turn_on, item.turn_on, item.position_bits};
            end
            default:
            begin
                desc.kind = dim_ok ? rfsw_pkg::KIND_DIM : rfsw_pkg::KIND_BAD;
                desc.syms = dim_syms;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/rfsw_queue.sv -----
`default_nettype none

module rfsw_queue
#(
    parameter int unsigned DEPTH = rfsw_pkg::QUEUE_DEPTH
)
(
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     push,
    input  wire rfsw_pkg::desc_t    push_data,
    input  wire                     pop,
    output rfsw_pkg::q_stat_t       stat,
    output rfsw_pkg::desc_t         head
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    rfsw_pkg::desc_t  entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];

    assign do_push = push && !stat.full;
    assign do_pop  = pop && stat.valid;

    always_comb
    begin
        wr_ptr_next = do_push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/rfsw_back.sv -----
`default_nettype none

module rfsw_back
(
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire rfsw_pkg::q_stat_t     stat,
    input  wire rfsw_pkg::desc_t       head,
    output logic                       pop,
    output logic                       strobe,
    output rfsw_pkg::out_word_t        result
);

    localparam int unsigned SYM_IDX_W = $clog2(rfsw_pkg::SYM_W);

    localparam logic [7:0] C_SP = 8'h20;
    localparam logic [7:0] C_BQ = 8'h60;
    localparam logic [7:0] C_RB = 8'h7D;
    localparam logic [7:0] C_PL = 8'h2B;
    localparam logic [7:0] C_DL = 8'h24;
    localparam logic [7:0] C_K  = 8'h6B;
    localparam logic [7:0] C_S  = 8'h53;
    localparam logic [7:0] C_T  = 8'h54;
    localparam logic [7:0] C_BS = 8'h5C;
    localparam logic [7:0] C_A  = 8'h41;

    logic                active_reg, active_next;
    logic                tok_done_reg, tok_done_next;
    logic [4:0]          tok_idx_reg, tok_idx_next;
    rfsw_pkg::desc_t     desc_reg, desc_next;
    logic [63:0]         buf_reg, buf_next;
    logic [2:0]          cnt_reg, cnt_next;
    logic                strobe_reg, strobe_next;
    rfsw_pkg::out_word_t result_reg, result_next;

    logic [31:0]          tok_chars;
    logic [2:0]           tok_len;
    logic                 tok_last;
    logic [SYM_IDX_W-1:0] sym_j;
    logic                 sym_bit;
    logic                 emit;
    logic                 emit_last;
    logic                 append;
    logic [2:0]           cnt_rem;
    logic [63:0]          buf_rem;

    // Token table: one token of up to four characters per cycle, first char low.
    always_comb
    begin
        sym_j = (desc_reg.kind == rfsw_pkg::KIND_DIM) ?
                SYM_IDX_W'(tok_idx_reg - 5'd3) : SYM_IDX_W'(tok_idx_reg - 5'd1);
        sym_bit   = (sym_j < SYM_IDX_W'(rfsw_pkg::SYM_W)) ? desc_reg.syms[sym_j] : 1'b0;
        tok_chars = 32'd0;
        tok_len   = 3'd0;
        tok_last  = 1'b0;
        unique case (desc_reg.kind)
            rfsw_pkg::KIND_TRI, rfsw_pkg::KIND_POS:
            begin
                priority if (tok_idx_reg == 5'd0)
                begin
                    tok_chars = {24'd0, C_S};
                    tok_len   = 3'd1;
                end
                else if (tok_idx_reg == 5'd13)
                begin
                    tok_len   = 3'd3;
                    tok_last  = 1'b1;
                    tok_chars = (desc_reg.kind == rfsw_pkg::KIND_TRI) ?
                                {8'd0, C_PL, C_RB, C_SP} : {8'd0, C_PL, C_K, C_DL};
                end
                else
                begin
                    tok_len = 3'd4;
                    if (desc_reg.kind == rfsw_pkg::KIND_TRI)
                    begin
                        tok_chars = sym_bit ? {C_SP, C_BQ, C_BQ, C_SP} :
                                              {C_BQ, C_SP, C_BQ, C_SP};
                    end
                    else
                    begin
                        tok_chars = sym_bit ? {C_K, C_DL, C_K, C_DL} :
                                              {C_DL, C_K, C_K, C_DL};
                    end
                end
            end
            rfsw_pkg::KIND_DIM:
            begin
                priority if (tok_idx_reg == 5'd0)
                begin
                    tok_chars = {C_T, C_T, C_T, C_S};
                    tok_len   = 3'd4;
                end
                else if (tok_idx_reg == 5'd1)
                begin
                    tok_chars = {C_BS, C_T, C_T, C_T};
                    tok_len   = 3'd4;
                end
                else if (tok_idx_reg == 5'd2)
                begin
                    tok_chars = {16'd0, C_A, C_A};
                    tok_len   = 3'd2;
                end
                else if (tok_idx_reg == 5'd27)
                begin
                    tok_chars = {24'd0, C_PL};
                    tok_len   = 3'd1;
                    tok_last  = 1'b1;
                end
                else
                begin
                    tok_chars = sym_bit ? {16'd0, C_T, C_T} : {8'd0, C_A, C_A, C_BS};
                    tok_len   = sym_bit ? 3'd2 : 3'd3;
                end
            end
            default:
            begin
                tok_last = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        emit      = active_reg && ((cnt_reg >= 3'd4) || (tok_done_reg && cnt_reg != 3'd0));
        emit_last = tok_done_reg && (cnt_reg <= 3'd4);
        append    = active_reg && !tok_done_reg;
        pop       = !active_reg && stat.valid;

        if (emit)
        begin
            buf_rem = {32'd0, buf_reg[63:32]};
            cnt_rem = emit_last ? 3'd0 : cnt_reg - 3'd4;
        end
        else
        begin
            buf_rem = buf_reg;
            cnt_rem = cnt_reg;
        end

        active_next   = active_reg;
        tok_done_next = tok_done_reg;
        tok_idx_next  = tok_idx_reg;
        desc_next     = desc_reg;
        buf_next      = buf_rem;
        cnt_next      = cnt_rem;

        strobe_next            = 1'b0;
        result_next            = result_reg;
        result_next.char0      = buf_reg[7:0];
        result_next.char1      = buf_reg[15:8];
        result_next.char2      = buf_reg[23:16];
        result_next.char3      = buf_reg[31:24];
        result_next.char_count = (cnt_reg >= 3'd4) ? 3'd4 : cnt_reg;
        result_next.last_chunk = emit_last;
        result_next.bad_params = 1'b0;

        if (emit)
        begin
            strobe_next = 1'b1;
            if (emit_last)
            begin
                active_next = 1'b0;
            end
        end

        // Place the new token right behind the characters still held.
        if (append)
        begin
            buf_next      = buf_rem | ({32'd0, tok_chars} << {cnt_rem[1:0], 3'b000});
            cnt_next      = cnt_rem + tok_len;
            tok_idx_next  = tok_idx_reg + 5'd1;
            tok_done_next = tok_last;
        end

        if (pop)
        begin
            if (head.kind == rfsw_pkg::KIND_BAD)
            begin
                strobe_next = 1'b1;
                result_next = '{char0: 8'd0, char1: 8'd0, char2: 8'd0, char3: 8'd0,
                                char_count: 3'd0, last_chunk: 1'b1, bad_params: 1'b1};
            end
            else
            begin
                active_next   = 1'b1;
                tok_done_next = 1'b0;
                tok_idx_next  = 5'd0;
                desc_next     = head;
                buf_next      = 64'd0;
                cnt_next      = 3'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 1'b0;
            tok_done_reg <= 1'b0;
            tok_idx_reg  <= 5'd0;
            cnt_reg      <= 3'd0;
            buf_reg      <= 64'd0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            active_reg   <= active_next;
            tok_done_reg <= tok_done_next;
            tok_idx_reg  <= tok_idx_next;
            cnt_reg      <= cnt_next;
            buf_reg      <= buf_next;
            strobe_reg   <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        desc_reg   <= desc_next;
        result_reg <= result_next;
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

// ----- hdl/rf_remote_switch_command_encoder_top.sv -----
// Channel   Direction  Handshake                 Word
// item      in         start high, busy low      rfsw_pkg::in_word_t
// result    out        strobe, one cycle         rfsw_pkg::out_word_t
//
// Each command is classified and queued; the back end adds one token of up to
// four characters per cycle and sends a chunk once four are held, or the rest
// once the last token is in. The queue takes a new word while the back end is
// still sending the last one; a bad command yields one empty final result.
// Reset clears queue and sequencer. busy is high while the queue is full; the
// receiver cannot stall and each result shows for one cycle only.
`default_nettype none
`include "rf_remote_switch_command_encoder_top_assert.svh"

module rf_remote_switch_command_encoder_top
#(
    parameter int unsigned QUEUE_DEPTH = rfsw_pkg::QUEUE_DEPTH
)
(
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         start,
    output logic                        busy,
    input  wire rfsw_pkg::in_word_t     item,
    output logic                        strobe,
    output rfsw_pkg::out_word_t         result
);

    rfsw_pkg::desc_t   front_desc;
    rfsw_pkg::desc_t   q_head;
    rfsw_pkg::q_stat_t q_stat;
    logic              push;
    logic              pop;

    assign busy = q_stat.full;
    assign push = start && !busy;

    rfsw_front u_front
    (
        .item (item),
        .desc (front_desc)
    );

    rfsw_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (front_desc),
        .pop       (pop),
        .stat      (q_stat),
        .head      (q_head)
    );

    rfsw_back u_back
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .stat   (q_stat),
        .head   (q_head),
        .pop    (pop),
        .strobe (strobe),
        .result (result)
    );

    `RFSW_ASSERT_IMPLY(a_bad_shape, clk, rst_n, strobe && result.bad_params,
        (result.char_count == 3'd0) && result.last_chunk, "bad result not empty and final")
    `RFSW_ASSERT_IMPLY(a_full_chunk, clk, rst_n, strobe && !result.last_chunk,
        result.char_count == 3'd4, "non-final chunk not full")
    `RFSW_ASSERT_NEVER(a_no_empty, clk, rst_n,
        strobe && !result.bad_params && (result.char_count == 3'd0), "empty chunk on valid command")
    `RFSW_ASSERT_NEXT(a_full_holds, clk, rst_n, q_stat.full && !pop, q_stat.full,
        "queue lost an entry")

endmodule

`default_nettype wire

// ----- dv/rf_remote_switch_command_encoder_top_tb.sv -----
module rf_remote_switch_command_encoder_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned IDLE_LIMIT   = 1000;
    localparam int unsigned RANDOM_WORDS = 420;
    localparam int unsigned DRAIN_CYCLES = 40;

    localparam byte unsigned BACKTICK     = 8'h60;
    localparam int unsigned  HOUSE_BASE   = 65;
    localparam int unsigned  TRI_MARK     = 6;
    localparam int unsigned  FADE_SMOOTH  = 8'hB0;
    localparam int unsigned  FADE_INSTANT = 8'h10;

    class chunk_scoreboard;
        rfsw_pkg::out_word_t expected_chunks[$];
        byte unsigned        line_buf[$];
        int                  errors;
        int                  chunks_seen;
        int                  rejected;
        int                  words_by_cmd[4];

        // Pattern strings write the backtick as ' so the preprocessor never sees it.
        function void put(string s);
            byte unsigned c;
            for (int i = 0; i < s.len(); i++)
            begin
                c = s[i];
                if (c == "'")
                    c = BACKTICK;
                line_buf.push_back(c);
            end
        endfunction

        function void put_sym(bit one);
            if (one)
                put("TT");
            else
                put("\\AA");
        endfunction

        function bit build_trinary(rfsw_pkg::in_word_t w);
            int unsigned code;
            int unsigned house;
            int unsigned chan;
            house = w.house_char;
            chan  = w.channel;
            if (house < HOUSE_BASE || house > HOUSE_BASE + 15 || chan < 1 || chan > 16)
                return 1'b0;
            code = (house - HOUSE_BASE) | ((chan - 1) << 4);
            // Variant drops the on/off suffix bits for an off command.
            if (!(w.cmd == rfsw_pkg::CMD_HOUSE_VAR && w.turn_on == 1'b0))
                code = code | (TRI_MARK << 8) | (32'(w.turn_on) << 11);
            put("S");
            for (int b = 0; b < 12; b++)
                put(code[b] ? " '' " : " ' '");
            put(" }+");
            return 1'b1;
        endfunction

        function void build_positions(rfsw_pkg::in_word_t w);
            put("S");
            for (int k = 0; k < 10; k++)
                put(w.position_bits[k] ? "$k$k" : "$kk$");
            put(w.turn_on ? "$k$k$kk$" : "$kk$$k$k");
            put("$k+");
        endfunction

        function bit build_dimmer(rfsw_pkg::in_word_t w);
            int unsigned dev;
            int unsigned sys;
            int unsigned lvl;
            int unsigned code;
            int unsigned word;
            int          odd;
            int          even;
            bit          b;
            dev = w.channel;
            sys = w.system_code;
            lvl = w.dim_level;
            if (dev < 1 || dev > 10 || sys < 1 || sys > 16 || lvl > 10)
                return 1'b0;
            if (dev == 10)
                dev = 0;
            code = ((sys - 1) << 10) | (1 << (9 - dev));
            put("STTTTTT\\AA");
            odd  = 0;
            even = 0;
            for (int i = 13; i >= 0; i--)
            begin
                b = code[i];
                put_sym(b);
                if (b)
                begin
                    if (i % 2 == 0)
                        even++;
                    else
                        odd++;
                end
            end
            put_sym(odd % 2 == 0);
            put_sym(even % 2 == 0);
            // Level runs inverted at the ends: 0 and 10 swap.
            if (lvl == 0)
                lvl = 10;
            else if (lvl == 10)
                lvl = 0;
            word = lvl | (w.smooth_fade ? FADE_SMOOTH : FADE_INSTANT);
            odd  = 0;
            even = 0;
            for (int i = 0; i < 6; i++)
            begin
                b = word[i];
                put_sym(b);
                if (b)
                begin
                    if (i % 2 == 0)
                        even++;
                    else
                        odd++;
                end
            end
            put_sym(even % 2 == 0);
            put_sym(odd % 2 == 0);
            put("+");
            return 1'b1;
        endfunction

        function void note_command(rfsw_pkg::in_word_t w);
            bit                  ok;
            rfsw_pkg::out_word_t chunk;
            int                  n;
            int                  cnt;
            int                  base;
            line_buf.delete();
            words_by_cmd[w.cmd]++;
            case (w.cmd)
                rfsw_pkg::CMD_TEN_POS:
                begin
                    build_positions(w);
                    ok = 1'b1;
                end
                rfsw_pkg::CMD_DIMMER: ok = build_dimmer(w);
                default:              ok = build_trinary(w);
            endcase
            if (!ok || line_buf.size() == 0)
            begin
                chunk            = '0;
                chunk.last_chunk = 1'b1;
                chunk.bad_params = 1'b1;
                expected_chunks.push_back(chunk);
                rejected++;
                return;
            end
            n = (line_buf.size() + 3) / 4;
            for (int k = 0; k < n; k++)
            begin
                base = 4 * k;
                cnt  = line_buf.size() - base;
                if (cnt > 4)
                    cnt = 4;
                chunk            = '0;
                chunk.char0      = line_buf[base];
                chunk.char1      = (cnt > 1) ? line_buf[base + 1] : 8'h00;
                chunk.char2      = (cnt > 2) ? line_buf[base + 2] : 8'h00;
                chunk.char3      = (cnt > 3) ? line_buf[base + 3] : 8'h00;
                chunk.char_count = 3'(cnt);
                chunk.last_chunk = (k == n - 1);
                expected_chunks.push_back(chunk);
            end
        endfunction

        function void check_chunk(rfsw_pkg::out_word_t got);
            rfsw_pkg::out_word_t want;
            chunks_seen++;
            if (expected_chunks.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected word, expected none, actual %h", $time, got);
                return;
            end
            want = expected_chunks.pop_front();
            if (got.char0 !== want.char0 || got.char1 !== want.char1 ||
                got.char2 !== want.char2 || got.char3 !== want.char3 ||
                got.char_count !== want.char_count || got.last_chunk !== want.last_chunk ||
                got.bad_params !== want.bad_params)
            begin
                errors++;
                $display("%0t: expected %h %h %h %h cnt %0d last %0b bad %0b,",
                         $time, want.char0, want.char1, want.char2, want.char3,
                         want.char_count, want.last_chunk, want.bad_params,
                         " actual %h %h %h %h cnt %0d last %0b bad %0b",
                         got.char0, got.char1, got.char2, got.char3,
                         got.char_count, got.last_chunk, got.bad_params);
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic                strobe;
    rfsw_pkg::in_word_t  item;
    rfsw_pkg::out_word_t result;
    int unsigned         idle_cycles;

    chunk_scoreboard sb = new;

    rf_remote_switch_command_encoder_top dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .strobe (strobe),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (strobe === 1'b1)
            sb.check_chunk(result);
    end

    initial
    begin
        idle_cycles = 0;
        wait (rst_n === 1'b1);
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((start === 1'b1 && busy === 1'b0) || strobe === 1'b1)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout after %0d idle cycles", IDLE_LIMIT);
        $display("rf_remote_switch_command_encoder_top: mismatch");
        $finish;
    end

    function automatic rfsw_pkg::in_word_t random_word();
        logic [63:0] bits;
        bits = {$urandom, $urandom};
        return bits[$bits(rfsw_pkg::in_word_t)-1:0];
    endfunction

    function automatic rfsw_pkg::in_word_t valid_word();
        rfsw_pkg::in_word_t w;
        w             = random_word();
        w.house_char  = 8'(HOUSE_BASE + $urandom_range(0, 15));
        w.channel     = (w.cmd == rfsw_pkg::CMD_DIMMER) ? 8'($urandom_range(1, 10))
                                                        : 8'($urandom_range(1, 16));
        w.system_code = 8'($urandom_range(1, 16));
        w.dim_level   = 8'($urandom_range(0, 10));
        return w;
    endfunction

    // Call at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_word(rfsw_pkg::in_word_t w, int unsigned gap);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        item  <= w;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        sb.note_command(w);
        @(negedge clk);
    endtask

    task automatic send_fields(logic [1:0] cmd, logic [7:0] house, logic [7:0] chan, bit on,
                               logic [9:0] pos, logic [7:0] sys, logic [7:0] lvl, bit smooth);
        rfsw_pkg::in_word_t w;
        w.cmd           = cmd;
        w.house_char    = house;
        w.channel       = chan;
        w.turn_on       = on;
        w.position_bits = pos;
        w.system_code   = sys;
        w.dim_level     = lvl;
        w.smooth_fade   = smooth;
        send_word(w, $urandom_range(0, 10));
    endtask

    // Hold off until every queued word has come out.
    task automatic drain();
        start <= 1'b0;
        while (sb.expected_chunks.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        rfsw_pkg::in_word_t w;
        int unsigned        gap;

        rst_n = 1'b0;
        start = 1'b0;
        item  = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        send_fields(rfsw_pkg::CMD_HOUSE, "A", 8'd1, 1'b1, 10'h000, 8'd0, 8'd0, 1'b0);
        send_fields(rfsw_pkg::CMD_HOUSE, "P", 8'd16, 1'b0, 10'h3FF, 8'hFF, 8'hFF, 1'b1);
        send_fields(rfsw_pkg::CMD_HOUSE, 8'd64, 8'd1, 1'b1, 10'h000, 8'd1, 8'd0, 1'b0);
        send_fields(rfsw_pkg::CMD_HOUSE, 8'd81, 8'd1, 1'b1, 10'h000, 8'd1, 8'd0, 1'b0);
        send_fields(rfsw_pkg::CMD_HOUSE, "C", 8'd0, 1'b1, 10'h000, 8'd1, 8'd0, 1'b0);
        send_fields(rfsw_pkg::CMD_HOUSE, "C", 8'd17, 1'b0, 10'h000, 8'd1, 8'd0, 1'b0);
        send_fields(rfsw_pkg::CMD_HOUSE, 8'd0, 8'd255, 1'b0, 10'h3FF, 8'd0, 8'd0, 1'b0);
        send_fields(rfsw_pkg::CMD_HOUSE, 8'd255, 8'd8, 1'b1, 10'h3FF, 8'hFF, 8'hFF, 1'b1);
        send_fields(rfsw_pkg::CMD_HOUSE_VAR, "B", 8'd5, 1'b1, 10'h000, 8'd0, 8'd0, 1'b0);
        send_fields(rfsw_pkg::CMD_HOUSE_VAR, "P", 8'd16, 1'b0, 10'h000, 8'd0, 8'd0, 1'b0);
        send_fields(rfsw_pkg::CMD_HOUSE_VAR, "A", 8'd1, 1'b0, 10'h3FF, 8'd0, 8'd0, 1'b1);
        send_fields(rfsw_pkg::CMD_HOUSE_VAR, "Z", 8'd3, 1'b0, 10'h000, 8'd0, 8'd0, 1'b0);
        send_fields(rfsw_pkg::CMD_TEN_POS, 8'd0, 8'd0, 1'b1, 10'h000, 8'd0, 8'd0, 1'b0);
        send_fields(rfsw_pkg::CMD_TEN_POS, 8'hFF, 8'hFF, 1'b0, 10'h3FF, 8'hFF, 8'hFF, 1'b1);
        send_fields(rfsw_pkg::CMD_TEN_POS, "A", 8'd1, 1'b1, 10'h155, 8'd1, 8'd0, 1'b0);
        send_fields(rfsw_pkg::CMD_TEN_POS, "A", 8'd1, 1'b0, 10'h2AA, 8'd1, 8'd0, 1'b0);
        send_fields(rfsw_pkg::CMD_DIMMER, "A", 8'd1, 1'b0, 10'h000, 8'd1, 8'd0, 1'b1);
        send_fields(rfsw_pkg::CMD_DIMMER, "A", 8'd10, 1'b1, 10'h3FF, 8'd16, 8'd10, 1'b0);
        send_fields(rfsw_pkg::CMD_DIMMER, "A", 8'd0, 1'b0, 10'h000, 8'd1, 8'd5, 1'b0);
        send_fields(rfsw_pkg::CMD_DIMMER, "A", 8'd11, 1'b0, 10'h000, 8'd1, 8'd5, 1'b0);
        send_fields(rfsw_pkg::CMD_DIMMER, "A", 8'd3, 1'b0, 10'h000, 8'd0, 8'd5, 1'b0);
        send_fields(rfsw_pkg::CMD_DIMMER, "A", 8'd3, 1'b0, 10'h000, 8'd17, 8'd5, 1'b1);
        send_fields(rfsw_pkg::CMD_DIMMER, "A", 8'd3, 1'b0, 10'h000, 8'd4, 8'd11, 1'b1);
        send_fields(rfsw_pkg::CMD_DIMMER, "A", 8'd3, 1'b0, 10'h000, 8'd4, 8'd255, 1'b0);
        send_fields(rfsw_pkg::CMD_DIMMER, "A", 8'd5, 1'b1, 10'h000, 8'd8, 8'd5, 1'b1);

        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i == RANDOM_WORDS / 2)
                drain();
            w = ($urandom_range(0, 99) < 85) ? valid_word() : random_word();
            // Every third stretch runs back to back.
            gap = ((i / 60) % 3 == 1) ? 0 : $urandom_range(0, 10);
            send_word(w, gap);
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("ran %0d commands: house %0d, variant %0d, ten-position %0d, dimmer %0d",
                 sb.words_by_cmd[0] + sb.words_by_cmd[1] +
                 sb.words_by_cmd[2] + sb.words_by_cmd[3],
                 sb.words_by_cmd[0], sb.words_by_cmd[1], sb.words_by_cmd[2],
                 sb.words_by_cmd[3]);
        $display("%0d rejected as bad parameters, %0d words checked, %0d errors",
                 sb.rejected, sb.chunks_seen, sb.errors);
        if (sb.errors == 0 && sb.expected_chunks.size() == 0)
            $display("rf_remote_switch_command_encoder_top: match");
        else
            $display("rf_remote_switch_command_encoder_top: mismatch");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/rfsw_pkg.sv
hdl/rfsw_front.sv
hdl/rfsw_queue.sv
hdl/rfsw_back.sv
hdl/rf_remote_switch_command_encoder_top.sv
dv/rf_remote_switch_command_encoder_top_tb.sv
